/* rtl/gfmi_pkg.sv */
package gfmi_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PolyW  = 9;
  localparam int unsigned DegW   = 4;
  localparam int unsigned MulCells = ByteW;
  localparam logic [PolyW-1:0] ModReset = 9'h11B;
  localparam logic [PolyW-1:0] ModTop   = 9'h100;

  localparam logic MODE_MUL = 1'b0;
  localparam logic MODE_INV = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_INV,
    ST_HOLD
  } gfmi_state_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] pw;
  } gfmi_mul_t;

  typedef struct packed {
    logic             done;
    logic [ByteW-1:0] res;
  } gfmi_inv_stat_t;

  function automatic logic [ByteW-1:0] xtime(input logic [ByteW-1:0] t,
                                             input logic [PolyW-1:0] m);
    logic [ByteW-1:0] r;
    r = {t[ByteW-2:0], 1'b0};
    if (t[ByteW-1]) r = r ^ m[ByteW-1:0];
    return r;
  endfunction

  function automatic logic [ByteW-1:0] xpow(input logic [ByteW-1:0] t,
                                            input logic [DegW-1:0] s,
                                            input logic [PolyW-1:0] m);
    logic [ByteW-1:0] r;
    r = t;
    for (int i = 0; i < ByteW; i++) begin
      if (DegW'(i) < s) r = xtime(r, m);
    end
    return r;
  endfunction

  function automatic logic [DegW-1:0] degree(input logic [PolyW-1:0] p);
    logic [DegW-1:0] d;
    d = '0;
    for (int i = 0; i < PolyW; i++) begin
      if (p[i]) d = DegW'(i);
    end
    return d;
  endfunction

endpackage

/* rtl/gf256_multiply_and_inverse_core.sv */
// Multiply: 8 cell stages, then result and output registers.
// Inverse: one division step or swap per cycle in the Euclid unit.
// One item at a time; the next item is taken once the result reaches the output register.
// Synchronous active-low reset clears control state and sets modulus to 0x11B.
module gf256_multiply_and_inverse_core import gfmi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_mode,
  input  logic [ByteW-1:0] in_operand_a,
  input  logic [ByteW-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  gfmi_state_t      state_r, state_nxt;
  logic [PolyW-1:0] mod_r, mod_nxt, mod_act;
  logic [ByteW-1:0] res_r, res_nxt, out_r, out_nxt;
  logic             oval_r, oval_nxt;
  logic             accept;
  gfmi_mul_t        links [MulCells+1];
  gfmi_inv_stat_t   inv_stat;

  assign pready  = 1'b1;
  assign prdata  = {{(32-PolyW){1'b0}}, mod_r};
  assign mod_act = mod_r | ModTop;
  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    mod_nxt = mod_r;
    if (psel && penable && pwrite && (paddr == 1'b0)) mod_nxt = pwdata[PolyW-1:0];
  end

  assign links[0].valid = accept && (in_mode == MODE_MUL);
  assign links[0].a     = in_operand_a;
  assign links[0].acc   = '0;
  assign links[0].pw    = in_operand_b;

  for (genvar g = 0; g < MulCells; g++) begin : g_cell
    gfmi_mul_cell #(.BitIdx(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .modulus (mod_act),
      .prev    (links[g]),
      .next    (links[g+1])
    );
  end

  gfmi_inv_unit u_inv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept && (in_mode == MODE_INV)),
    .a       (in_operand_a),
    .modulus (mod_act),
    .stat    (inv_stat)
  );

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    oval_nxt  = oval_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = (in_mode == MODE_INV) ? ST_INV : ST_MUL;
      end
      ST_MUL: begin
        if (links[MulCells].valid) begin
          res_nxt   = links[MulCells].acc;
          state_nxt = ST_HOLD;
        end
      end
      ST_INV: begin
        if (inv_stat.done) begin
          res_nxt   = inv_stat.res;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!oval_r || out_ready) begin
          out_nxt   = res_r;
          oval_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
      mod_r   <= ModReset;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
      mod_r   <= mod_nxt;
    end
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid  = oval_r;
  assign out_result = out_r;

endmodule

/* rtl/gfmi_mul_cell.sv */
module gfmi_mul_cell import gfmi_pkg::*; #(
  parameter int unsigned BitIdx = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [PolyW-1:0] modulus,
  input  gfmi_mul_t        prev,
  output gfmi_mul_t        next
);

  gfmi_mul_t cell_r, cell_nxt;

  always_comb begin
    cell_nxt       = prev;
    cell_nxt.acc   = prev.a[BitIdx] ? (prev.acc ^ prev.pw) : prev.acc;
    cell_nxt.pw    = xtime(prev.pw, modulus);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.a   <= cell_nxt.a;
    cell_r.acc <= cell_nxt.acc;
    cell_r.pw  <= cell_nxt.pw;
  end

  assign next = cell_r;

endmodule

/* rtl/gfmi_inv_unit.sv */
module gfmi_inv_unit import gfmi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ByteW-1:0] a,
  input  logic [PolyW-1:0] modulus,
  output gfmi_inv_stat_t   stat
);

  logic             busy_r, busy_nxt;
  logic [PolyW-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [ByteW-1:0] ta_r, ta_nxt, tb_r, tb_nxt;
  logic [DegW-1:0]  deg_a, deg_b, sh;

  always_comb begin
    busy_nxt  = busy_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    stat.done = 1'b0;
    stat.res  = (ra_r == PolyW'(1)) ? ta_r : '0;
    deg_a     = degree(ra_r);
    deg_b     = degree(rb_r);
    sh        = deg_a - deg_b;
    if (start) begin
      busy_nxt = 1'b1;
      ra_nxt   = modulus;
      rb_nxt   = {1'b0, a};
      ta_nxt   = '0;
      tb_nxt   = ByteW'(1);
    end else if (busy_r) begin
      if (rb_r == '0) begin
        busy_nxt  = 1'b0;
        stat.done = 1'b1;
      end else if ((ra_r == '0) || (deg_a < deg_b)) begin
        ra_nxt = rb_r;
        rb_nxt = ra_r;
        ta_nxt = tb_r;
        tb_nxt = ta_r;
      end else begin
        ra_nxt = ra_r ^ PolyW'(rb_r << sh);
        ta_nxt = ta_r ^ xpow(tb_r, sh, modulus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    ta_r <= ta_nxt;
    tb_r <= tb_nxt;
  end

endmodule

/* dv/gf256_multiply_and_inverse_core_test.sv */
module gf256_multiply_and_inverse_core_test import gfmi_pkg::*; ();

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
  } gf_op_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_mode = 1'b0;
  logic [ByteW-1:0] in_operand_a = '0;
  logic [ByteW-1:0] in_operand_b = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ByteW-1:0] out_result;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic             paddr = 1'b0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  gf256_multiply_and_inverse_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_result(out_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  gf_op_t           op_q[$];
  logic [ByteW-1:0] want_q[$];
  logic [PolyW-1:0] poly_now = ModReset;
  int               errors = 0;
  int               n_sent = 0;
  int               n_seen = 0;
  int               n_inv = 0;
  bit               calm = 1'b0;
  int               drv_gap = 0;
  int               mon_gap = 0;

  function automatic int deg_of(logic [16:0] p);
    int d;
    d = -1;
    for (int i = 0; i < 17; i++) if (p[i]) d = i;
    return d;
  endfunction

  function automatic logic [ByteW-1:0] reduce17(logic [16:0] p, logic [PolyW-1:0] m);
    for (int i = 16; i >= 8; i--) if (p[i]) p = p ^ (17'(m) << (i - 8));
    return p[7:0];
  endfunction

  function automatic logic [ByteW-1:0] gf_product(logic [7:0] a, logic [7:0] b,
                                                  logic [PolyW-1:0] m);
    logic [16:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) if (a[i]) p = p ^ (17'(b) << i);
    return reduce17(p, m);
  endfunction

  function automatic logic [ByteW-1:0] gf_recip(logic [7:0] a, logic [PolyW-1:0] m);
    logic [16:0] r0, r1, q, r, t0, t1, t2, pr;
    int dd, dn;
    if (a == 0) return 0;
    if (a == 1) return 1;
    r0 = 17'(m); r1 = 17'(a); t0 = 0; t1 = 1;
    for (int k = 0; k < 16 && r1 != 0; k++) begin
      q = 0; r = r0; dd = deg_of(r1);
      for (int j = 0; j < 32; j++) begin
        dn = deg_of(r);
        if (dn < dd) break;
        r = r ^ (r1 << (dn - dd));
        q[dn - dd] = 1'b1;
      end
      pr = '0;
      for (int i = 0; i < 9; i++) if (q[i]) pr = pr ^ (17'(t1[7:0]) << i);
      t2 = t0 ^ 17'(reduce17(pr, m));
      r0 = r1; r1 = r; t0 = t1; t1 = t2;
    end
    if (r0 != 1) return 0;
    return t0[7:0];
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
    $display("mismatch %s: got %02h expected %02h", what, got, exp);
    errors++;
  endtask

  task automatic push_op(logic mode, logic [7:0] a, logic [7:0] b);
    op_q.push_back('{mode, a, b});
  endtask

  task automatic cfg_write(logic [PolyW-1:0] m);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= 32'(m); penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    poly_now = m | ModTop;
  endtask

  task automatic drain;
    while (op_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want_q.push_back(in_mode == MODE_MUL ?
                         gf_product(in_operand_a, in_operand_b, poly_now) :
                         gf_recip(in_operand_a, poly_now));
        n_sent++;
        if (in_mode == MODE_INV) n_inv++;
      end
      if (!in_valid || in_ready) begin
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          gf_op_t o;
          o = op_q.pop_front();
          in_valid <= 1'b1;
          in_mode <= o.mode; in_operand_a <= o.a; in_operand_b <= o.b;
          if (!calm && $urandom_range(0, 5) == 0) drv_gap <= $urandom_range(1, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_seen++;
        if (want_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_result, 8'h00);
        end else begin
          logic [7:0] e;
          e = want_q.pop_front();
          if (out_result !== e) report_mismatch("result", out_result, e);
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        mon_gap <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [PolyW-1:0] mods[6];
    mods = '{9'h11B, 9'h11D, 9'h1FF, 9'h100, 9'h0A5, 9'h1F5};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    push_op(MODE_INV, 8'h00, 8'hFF);
    push_op(MODE_INV, 8'h01, 8'h00);
    push_op(MODE_INV, 8'hFF, 8'hAA);
    push_op(MODE_INV, 8'h53, 8'h00);
    push_op(MODE_INV, 8'h80, 8'h55);
    push_op(MODE_INV, 8'h02, 8'h00);
    push_op(MODE_MUL, 8'h00, 8'hFF);
    push_op(MODE_MUL, 8'hFF, 8'h00);
    push_op(MODE_MUL, 8'hFF, 8'hFF);
    push_op(MODE_MUL, 8'h80, 8'h80);
    push_op(MODE_MUL, 8'h01, 8'hA5);
    push_op(MODE_MUL, 8'h57, 8'h83);
    push_op(MODE_MUL, 8'h55, 8'hAA);
    drain();
    cfg_write(9'h1FF);
    push_op(MODE_INV, 8'h03, 8'h00);
    push_op(MODE_INV, 8'hFF, 8'h00);
    push_op(MODE_INV, 8'h11, 8'h00);
    push_op(MODE_MUL, 8'hFF, 8'hFF);
    drain();
    cfg_write(9'h100);
    push_op(MODE_INV, 8'h02, 8'h00);
    push_op(MODE_INV, 8'h03, 8'h00);
    push_op(MODE_MUL, 8'h80, 8'h02);
    drain();
    for (int p = 0; p < 6; p++) begin
      cfg_write(p < 5 ? mods[p] : 9'($urandom_range(256, 511)));
      for (int i = 0; i < 180; i++) begin
        push_op(1'($urandom), 8'($urandom), 8'($urandom));
        if (p == 5 && i == 90) begin
          while (op_q.size() != 0 || in_valid || want_q.size() != 0) @(posedge clk);
        end
        if (p == 5 && i == 120) calm = 1'b1;
      end
      drain();
    end
    $display("covered %0d transfers in, %0d out, %0d inverses, 9 modulus settings",
             n_sent, n_seen, n_inv);
    if (errors == 0 && want_q.size() == 0) begin
      $display("gf256_multiply_and_inverse_core test passed");
    end else begin
      $display("gf256_multiply_and_inverse_core test failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("gf256_multiply_and_inverse_core test failed");
    $finish;
  end

endmodule
